// ===== rtl/lgcs_pkg.sv =====
// Shared constants and types of the Laplacian/gradient corner score block.
// Used by every module under rtl; depends on nothing.
package lgcs_pkg;

  localparam int MAX_WIDTH    = 2048;
  localparam int MAX_HEIGHT   = 2048;
  localparam int MAX_CHANNELS = 4;

  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = 12;
  localparam int CHAN_W  = 16;
  localparam int PIX_W   = CHAN_W * MAX_CHANNELS;
  localparam int SCORE_W = 36;
  localparam int KAPPA_W = 16;
  localparam int NCH_W   = 3;
  localparam int LAP_W   = 20;
  localparam int DIFF_W  = 17;
  localparam int SQ_W    = 34;
  localparam int RAD_W   = SQ_W + 16;
  localparam int ROOT_W  = RAD_W / 2;
  localparam int REM_W   = ROOT_W + 2;
  localparam int PROD_W  = KAPPA_W + ROOT_W;
  localparam int TERM_W  = 38;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KAPPA_Q8      = 3'd3;

  localparam logic [ROW_W-1:0] WIDTH_LIMIT  = ROW_W'(MAX_WIDTH);
  localparam logic [ROW_W-1:0] HEIGHT_LIMIT = ROW_W'(MAX_HEIGHT);
  localparam logic [NCH_W-1:0] CHAN_LIMIT   = NCH_W'(MAX_CHANNELS);

  // Effective (clamped) configuration.
  typedef struct packed {
    logic [ROW_W-1:0]   width;
    logic [ROW_W-1:0]   height;
    logic [NCH_W-1:0]   nchan;
    logic [KAPPA_W-1:0] kappa;
  } cfg_t;

  // One score job: center pixel and its four neighbors, zeros outside the frame.
  typedef struct packed {
    logic [PIX_W-1:0] p;
    logic [PIX_W-1:0] l;
    logic [PIX_W-1:0] r;
    logic [PIX_W-1:0] u;
    logic [PIX_W-1:0] d;
    logic             frame_end;
  } job_t;

endpackage

// ===== rtl/lgcs_front.sv =====
// Front part: raster counters, the two line buffers and neighbor gathering.
// Depends on lgcs_pkg; emits one job_t per scored pixel.
module lgcs_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lgcs_pkg::cfg_t              cfg,
  input  logic                        in_push,
  output logic                        in_full,
  input  logic [lgcs_pkg::PIX_W-1:0]  in_pix,
  input  logic                        in_drain,
  output logic                        job_valid,
  input  logic                        job_ready,
  output lgcs_pkg::job_t              job
);

  typedef enum logic [4:0] {
    F_IDLE = 5'b00001,
    F_RD0  = 5'b00010,
    F_RD1  = 5'b00100,
    F_RD2  = 5'b01000,
    F_PUSH = 5'b10000
  } front_state_t;

  front_state_t state_r, state_nxt;

  logic [lgcs_pkg::COL_W-1:0] in_col_r, in_col_nxt;
  logic [lgcs_pkg::ROW_W-1:0] in_row_r, in_row_nxt;
  logic [lgcs_pkg::COL_W-1:0] out_col_r, out_col_nxt;
  logic [lgcs_pkg::COL_W-1:0] out_row_r, out_row_nxt;
  logic [lgcs_pkg::PIX_W-1:0] left_r, left_nxt;

  logic [lgcs_pkg::COL_W-1:0] col_r;
  logic [lgcs_pkg::PIX_W-1:0] cur_r, p_r, u_r, rt_r, lf_r;
  logic flush_r, emit_r, fend_r, lastc_r, up_en_r, rt_en_r, lf_en_r;

  logic [lgcs_pkg::PIX_W-1:0] center_mem [lgcs_pkg::MAX_WIDTH];
  logic [lgcs_pkg::PIX_W-1:0] above_mem  [lgcs_pkg::MAX_WIDTH];
  logic [lgcs_pkg::PIX_W-1:0] cen_q, abv_q;
  logic [lgcs_pkg::COL_W-1:0] cen_addr;
  logic                       wr_en;

  logic                       accept, is_flush;
  logic [lgcs_pkg::COL_W-1:0] sel_col;
  logic [lgcs_pkg::ROW_W-1:0] col_plus;
  logic                       sel_last;

  assign in_full  = (state_r != F_IDLE);
  assign accept   = (state_r == F_IDLE) && in_push;
  assign is_flush = (in_row_r >= cfg.height);
  assign sel_col  = is_flush ? out_col_r : in_col_r;
  assign col_plus = {1'b0, sel_col} + 1'b1;
  assign sel_last = (col_plus >= cfg.width);

  always_comb begin
    case (state_r)
      F_RD1:   cen_addr = col_r + 1'b1;
      F_RD2,
      F_PUSH:  cen_addr = col_r - 1'b1;
      default: cen_addr = col_r;
    endcase
  end

  assign wr_en     = (state_r == F_PUSH) && !flush_r && (!emit_r || job_ready);
  assign job_valid = (state_r == F_PUSH) && emit_r;

  always_comb begin
    job.p         = p_r;
    job.l         = flush_r ? (lf_en_r ? cen_q : '0) : lf_r;
    job.r         = rt_r;
    job.u         = u_r;
    job.d         = flush_r ? '0 : cur_r;
    job.frame_end = fend_r;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      center_mem[col_r] <= cur_r;
      above_mem[col_r]  <= p_r;
    end
    cen_q <= center_mem[cen_addr];
    abv_q <= above_mem[col_r];
  end

  always_comb begin
    state_nxt   = state_r;
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    left_nxt    = left_r;
    case (state_r)
      F_IDLE: begin
        if (accept) begin
          if (is_flush) begin
            state_nxt = F_RD0;
            if (sel_last) begin
              in_col_nxt  = '0;
              in_row_nxt  = '0;
              out_col_nxt = '0;
              out_row_nxt = '0;
              left_nxt    = '0;
            end else begin
              out_col_nxt = col_plus[lgcs_pkg::COL_W-1:0];
            end
          end else if (!in_drain) begin
            state_nxt = F_RD0;
            if (sel_last) begin
              in_col_nxt = '0;
              in_row_nxt = in_row_r + 1'b1;
              if ((in_row_r + 1'b1) >= cfg.height) begin
                out_col_nxt = '0;
                out_row_nxt = lgcs_pkg::COL_W'(cfg.height - 1'b1);
              end
            end else begin
              in_col_nxt = col_plus[lgcs_pkg::COL_W-1:0];
            end
          end
        end
      end
      F_RD0:   state_nxt = F_RD1;
      F_RD1:   state_nxt = F_RD2;
      F_RD2:   state_nxt = F_PUSH;
      F_PUSH: begin
        if (!emit_r || job_ready) begin
          state_nxt = F_IDLE;
          if (!flush_r) begin
            left_nxt = lastc_r ? '0 : p_r;
          end
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= F_IDLE;
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      left_r    <= '0;
    end else begin
      state_r   <= state_nxt;
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      left_r    <= left_nxt;
    end
  end

  // Per-item payload, captured at accept and through the read sequence.
  always_ff @(posedge clk) begin
    if (accept) begin
      col_r   <= sel_col;
      flush_r <= is_flush;
      cur_r   <= in_pix;
      lastc_r <= sel_last;
      rt_en_r <= !sel_last;
      lf_en_r <= (sel_col != '0);
      lf_r    <= (sel_col != '0) ? left_r : '0;
      if (is_flush) begin
        emit_r  <= 1'b1;
        fend_r  <= sel_last;
        up_en_r <= (out_row_r != '0);
      end else begin
        emit_r  <= (in_row_r != '0);
        fend_r  <= 1'b0;
        up_en_r <= (in_row_r >= 2);
      end
    end
    if (state_r == F_RD1) begin
      p_r <= cen_q;
      u_r <= up_en_r ? abv_q : '0;
    end
    if (state_r == F_RD2) begin
      rt_r <= rt_en_r ? cen_q : '0;
    end
  end

endmodule

// ===== rtl/lgcs_queue.sv =====
// Two-entry job queue that decouples the front and back parts.
// Depends on lgcs_pkg for job_t.
module lgcs_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  output logic           full,
  input  lgcs_pkg::job_t wdata,
  input  logic           pop,
  output logic           empty,
  output lgcs_pkg::job_t rdata
);

  lgcs_pkg::job_t mem_r [2];
  logic       wptr_r, rptr_r;
  logic [1:0] count_r;
  logic       do_push, do_pop;

  assign full    = (count_r == 2'd2);
  assign empty   = (count_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= 1'b0;
      rptr_r  <= 1'b0;
      count_r <= 2'd0;
    end else begin
      if (do_push) wptr_r <= !wptr_r;
      if (do_pop)  rptr_r <= !rptr_r;
      count_r <= count_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

// ===== rtl/lgcs_back.sv =====
// Back part: per-channel Laplacian, gradient square root and score sum.
// Depends on lgcs_pkg; holds the one-word result register.
module lgcs_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  lgcs_pkg::cfg_t                 cfg,
  input  logic                           job_valid,
  output logic                           job_pop,
  input  lgcs_pkg::job_t                 job,
  output logic                           out_empty,
  input  logic                           out_pop,
  output logic [lgcs_pkg::SCORE_W-1:0]   out_score,
  output logic                           out_fend
);

  typedef enum logic [5:0] {
    B_IDLE = 6'b000001,
    B_SQ   = 6'b000010,
    B_ROOT = 6'b000100,
    B_MUL  = 6'b001000,
    B_SUM  = 6'b010000,
    B_DONE = 6'b100000
  } back_state_t;

  localparam int NCH = lgcs_pkg::MAX_CHANNELS;
  localparam int CW  = lgcs_pkg::CHAN_W;
  localparam int STEP_W = $clog2(lgcs_pkg::ROOT_W);

  back_state_t state_r, state_nxt;
  logic [STEP_W-1:0] step_r;
  logic              fend_r;
  logic              out_valid_r;
  logic              load_out;
  logic [lgcs_pkg::SCORE_W-1:0] sum_r;

  logic signed [lgcs_pkg::LAP_W-1:0]  lap_r  [NCH];
  logic signed [lgcs_pkg::DIFF_W-1:0] dx_r   [NCH];
  logic signed [lgcs_pkg::DIFF_W-1:0] dy_r   [NCH];
  logic [lgcs_pkg::RAD_W-1:0]         rad_r  [NCH];
  logic [lgcs_pkg::REM_W-1:0]         rem_r  [NCH];
  logic [lgcs_pkg::ROOT_W-1:0]        root_r [NCH];
  logic [lgcs_pkg::PROD_W-1:0]        prod_r [NCH];
  logic signed [lgcs_pkg::TERM_W-1:0] term   [NCH];
  logic signed [lgcs_pkg::TERM_W-1:0] total;

  assign job_pop   = (state_r == B_IDLE) && job_valid;
  assign load_out  = (state_r == B_DONE) && (!out_valid_r || out_pop);
  assign out_empty = !out_valid_r;

  for (genvar k = 0; k < NCH; k++) begin : g_lane
    logic signed [CW-1:0] pc, pl, pr, pu, pd;
    logic signed [lgcs_pkg::LAP_W-1:0]    lap;
    logic signed [2*lgcs_pkg::DIFF_W-1:0] sqx, sqy;
    logic [lgcs_pkg::SQ_W-1:0]            sqsum;
    logic [lgcs_pkg::REM_W-1:0]           rem_sh, trial;
    logic                                 ge;

    assign pc = job.p[k*CW +: CW];
    assign pl = job.l[k*CW +: CW];
    assign pr = job.r[k*CW +: CW];
    assign pu = job.u[k*CW +: CW];
    assign pd = job.d[k*CW +: CW];
    assign lap = (lgcs_pkg::LAP_W'(pc) <<< 2) - lgcs_pkg::LAP_W'(pl)
               - lgcs_pkg::LAP_W'(pr) - lgcs_pkg::LAP_W'(pu) - lgcs_pkg::LAP_W'(pd);

    assign sqx   = dx_r[k] * dx_r[k];
    assign sqy   = dy_r[k] * dy_r[k];
    assign sqsum = lgcs_pkg::SQ_W'(sqx) + lgcs_pkg::SQ_W'(sqy);

    // One restoring square-root step: two radicand bits in, one root bit out.
    assign rem_sh = {rem_r[k][lgcs_pkg::REM_W-3:0],
                     rad_r[k][lgcs_pkg::RAD_W-1 -: 2]};
    assign trial  = {root_r[k], 2'b01};
    assign ge     = (rem_sh >= trial);

    assign term[k] = (lgcs_pkg::TERM_W'(lap_r[k]) <<< 8)
                   - $signed({{(lgcs_pkg::TERM_W-lgcs_pkg::PROD_W+8){1'b0}},
                              prod_r[k][lgcs_pkg::PROD_W-1:8]});

    always_ff @(posedge clk) begin
      case (state_r)
        B_IDLE: begin
          if (job_valid) begin
            lap_r[k] <= lap;
            dx_r[k]  <= lgcs_pkg::DIFF_W'(pr) - lgcs_pkg::DIFF_W'(pl);
            dy_r[k]  <= lgcs_pkg::DIFF_W'(pd) - lgcs_pkg::DIFF_W'(pu);
          end
        end
        B_SQ: begin
          rad_r[k]  <= {sqsum, 16'b0};
          rem_r[k]  <= '0;
          root_r[k] <= '0;
        end
        B_ROOT: begin
          rad_r[k]  <= rad_r[k] << 2;
          rem_r[k]  <= ge ? (rem_sh - trial) : rem_sh;
          root_r[k] <= {root_r[k][lgcs_pkg::ROOT_W-2:0], ge};
        end
        B_MUL: begin
          prod_r[k] <= lgcs_pkg::PROD_W'(cfg.kappa) * lgcs_pkg::PROD_W'(root_r[k]);
        end
        default: ;
      endcase
    end
  end

  // Only the configured channels contribute.
  always_comb begin
    total = '0;
    for (int k = 0; k < NCH; k++) begin
      if (k < int'(cfg.nchan)) total = total + term[k];
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE:  if (job_valid) state_nxt = B_SQ;
      B_SQ:    state_nxt = B_ROOT;
      B_ROOT:  if (step_r == '0) state_nxt = B_MUL;
      B_MUL:   state_nxt = B_SUM;
      B_SUM:   state_nxt = B_DONE;
      B_DONE:  if (load_out) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) out_valid_r <= 1'b1;
      else if (out_pop) out_valid_r <= 1'b0;
    end
  end

  // The sum waits in sum_r until the result register is free, so a word
  // that is still waiting to be popped is never overwritten.
  always_ff @(posedge clk) begin
    if (job_pop) fend_r <= job.frame_end;
    if (state_r == B_SQ) step_r <= STEP_W'(lgcs_pkg::ROOT_W - 1);
    else if (state_r == B_ROOT) step_r <= step_r - 1'b1;
    if (state_r == B_SUM) sum_r <= total[lgcs_pkg::SCORE_W-1:0];
    if (load_out) begin
      out_score <= sum_r;
      out_fend  <= fend_r;
    end
  end

endmodule

// ===== rtl/laplacian_gradient_corner_score_top.sv =====
// Laplacian-minus-gradient corner score block, top level.
// Depends on lgcs_pkg, lgcs_front, lgcs_queue and lgcs_back.
//
// Pixels of up to four signed 16-bit channels are pushed in raster order;
// each pixel is scored when the pixel below it arrives, and once the frame
// is complete the last row is flushed by further words (drain words, or
// pixel words whose samples are then dropped), one score per word, the
// final one marked frame_end. The front part takes a word in steps: an
// accept in idle, three reads of the two line-buffer memories (one read
// port each), and a hand-off with write-back that waits while the queue is
// full; no new word is taken before that. Drain words during input are
// accepted and dropped in idle. The back part scores one job at a time
// through the 25-step bit-serial square root that all channels run side by
// side, and a two-word queue lets the front run ahead. Configuration is
// written over cfg_valid/cfg_ready (always ready) and must only change while
// the block is idle. The line buffers need no clearing pass after reset.
module laplacian_gradient_corner_score_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_push,
  output logic                              in_full,
  input  logic signed [15:0]                in_chan0,
  input  logic signed [15:0]                in_chan1,
  input  logic signed [15:0]                in_chan2,
  input  logic signed [15:0]                in_chan3,
  input  logic                              in_drain,
  output logic                              out_empty,
  input  logic                              out_pop,
  output logic signed [35:0]                out_score_q8,
  output logic                              out_frame_end,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lgcs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lgcs_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic [lgcs_pkg::ROW_W-1:0]   width_r, height_r;
  logic [lgcs_pkg::NCH_W-1:0]   nchan_r;
  logic [lgcs_pkg::KAPPA_W-1:0] kappa_r;
  lgcs_pkg::cfg_t               cfg;

  lgcs_pkg::job_t fq_wdata, fq_rdata;
  logic           fq_push, fq_full, fq_pop, fq_empty;
  logic [lgcs_pkg::SCORE_W-1:0] score;

  assign cfg_ready = 1'b1;

  // Register writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= lgcs_pkg::ROW_W'(640);
      height_r <= lgcs_pkg::ROW_W'(480);
      nchan_r  <= lgcs_pkg::NCH_W'(1);
      kappa_r  <= lgcs_pkg::KAPPA_W'(256);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lgcs_pkg::CFG_FRAME_WIDTH:   width_r  <= cfg_data[lgcs_pkg::ROW_W-1:0];
        lgcs_pkg::CFG_FRAME_HEIGHT:  height_r <= cfg_data[lgcs_pkg::ROW_W-1:0];
        lgcs_pkg::CFG_CHANNEL_COUNT: nchan_r  <= cfg_data[lgcs_pkg::NCH_W-1:0];
        lgcs_pkg::CFG_KAPPA_Q8:      kappa_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // For width, height and channel count, zero acts as one, and values above the hardware limits are clamped.
  always_comb begin
    cfg.width  = (width_r == '0) ? lgcs_pkg::ROW_W'(1) :
                 (width_r > lgcs_pkg::WIDTH_LIMIT) ? lgcs_pkg::WIDTH_LIMIT : width_r;
    cfg.height = (height_r == '0) ? lgcs_pkg::ROW_W'(1) :
                 (height_r > lgcs_pkg::HEIGHT_LIMIT) ? lgcs_pkg::HEIGHT_LIMIT : height_r;
    cfg.nchan  = (nchan_r == '0) ? lgcs_pkg::NCH_W'(1) :
                 (nchan_r > lgcs_pkg::CHAN_LIMIT) ? lgcs_pkg::CHAN_LIMIT : nchan_r;
    cfg.kappa  = kappa_r;
  end

  lgcs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_pix    ({in_chan3, in_chan2, in_chan1, in_chan0}),
    .in_drain  (in_drain),
    .job_valid (fq_push),
    .job_ready (!fq_full),
    .job       (fq_wdata)
  );

  lgcs_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fq_push),
    .full  (fq_full),
    .wdata (fq_wdata),
    .pop   (fq_pop),
    .empty (fq_empty),
    .rdata (fq_rdata)
  );

  lgcs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .job_valid (!fq_empty),
    .job_pop   (fq_pop),
    .job       (fq_rdata),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_score (score),
    .out_fend  (out_frame_end)
  );

  assign out_score_q8 = $signed(score);

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench of laplacian_gradient_corner_score_top.
// Depends on lgcs_pkg and the block's RTL; a behavioral scorer predicts every word.
`timescale 1ns / 100ps

module tb;

  localparam int MAXW = 2048;
  localparam int MAXH = 2048;
  localparam int SETTLE = 100;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int RANDOM_WORDS = 330;

  // Register indexes past the end of the list.
  localparam logic [lgcs_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd4;
  localparam logic [lgcs_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  typedef struct {
    logic [35:0] score;
    logic        fend;
  } score_word_t;

  logic clk;
  logic rst_n;
  logic in_push;
  logic in_full;
  logic signed [15:0] in_chan0, in_chan1, in_chan2, in_chan3;
  logic in_drain;
  logic out_empty;
  logic out_pop;
  logic signed [35:0] out_score_q8;
  logic out_frame_end;
  logic cfg_valid;
  logic cfg_ready;
  logic [lgcs_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [lgcs_pkg::CFG_DATA_W-1:0] cfg_data;

  laplacian_gradient_corner_score_top DUT (.*);

  // Scorer state: line buffers, positions and register copies.
  logic [63:0] buf_above [MAXW];
  logic [63:0] buf_center [MAXW];
  logic [63:0] left_pix;
  int unsigned col_in, row_in, col_out, row_out;
  int unsigned reg_width, reg_height, reg_chans, reg_kappa;

  score_word_t scores_due[$];
  int errors;
  int words_sent;
  int scores_seen;
  int frames_done;
  int pop_hold;
  longint cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // Sum over the used channels of lap*256 minus the weighted gradient magnitude.
  function automatic logic [35:0] corner_score(logic [63:0] p, logic [63:0] l, logic [63:0] r,
                                               logic [63:0] u, logic [63:0] d);
    longint sum, pc, pl, pr, pu, pd, lap, dx, dy;
    longint unsigned sq, grad;
    int unsigned nch;
    sum = 0;
    nch = (reg_chans == 0) ? 1 : ((reg_chans > 4) ? 4 : reg_chans);
    for (int k = 0; k < nch; k++) begin
      pc = $signed(p[16*k +: 16]);
      pl = $signed(l[16*k +: 16]);
      pr = $signed(r[16*k +: 16]);
      pu = $signed(u[16*k +: 16]);
      pd = $signed(d[16*k +: 16]);
      lap = 4 * pc - pl - pr - pu - pd;
      dx = pr - pl;
      dy = pd - pu;
      sq = longint'(dx * dx + dy * dy) * 65536;
      grad = (longint'(reg_kappa) * int_sqrt(sq)) >> 8;
      sum += lap * 256 - longint'(grad);
    end
    return sum[35:0];
  endfunction

  // Advances the scorer by one accepted word and queues the score it causes.
  task automatic predict_word(logic [63:0] pix, bit drain);
    int unsigned w, h, c, r;
    logic [63:0] lft, rgt, up, old;
    score_word_t s;
    w = clamp_dim(reg_width, MAXW);
    h = clamp_dim(reg_height, MAXH);
    if (row_in >= h) begin
      // The frame is complete: every word flushes one score of the last row.
      c = (col_out < MAXW) ? col_out : MAXW - 1;
      lft = (c > 0) ? buf_center[c-1] : '0;
      rgt = (c + 1 < w) ? buf_center[c+1] : '0;
      up = (row_out >= 1) ? buf_above[c] : '0;
      s.score = corner_score(buf_center[c], lft, rgt, up, '0);
      s.fend = (c + 1 >= w);
      scores_due.push_back(s);
      if (s.fend) begin
        col_in = 0; row_in = 0; col_out = 0; row_out = 0;
        left_pix = '0;
        frames_done++;
      end else begin
        col_out = c + 1;
      end
    end else if (!drain) begin
      c = (col_in < MAXW) ? col_in : MAXW - 1;
      r = row_in;
      old = buf_center[c];
      if (r >= 1) begin
        lft = (c > 0) ? left_pix : '0;
        rgt = (c + 1 < w) ? buf_center[c+1] : '0;
        up = (r >= 2) ? buf_above[c] : '0;
        s.score = corner_score(old, lft, rgt, up, pix);
        s.fend = 1'b0;
        scores_due.push_back(s);
      end
      left_pix = old;
      buf_above[c] = old;
      buf_center[c] = pix;
      if (c + 1 >= w) begin
        col_in = 0;
        row_in = r + 1;
        left_pix = '0;
        if (row_in >= h) begin
          col_out = 0;
          row_out = (h - 1) & 11'h7FF;
        end
      end else begin
        col_in = c + 1;
      end
    end
  endtask

  // Offers one word after a random gap; returns once the block took it.
  task automatic send_word(logic [63:0] pix, bit drain);
    int gap;
    gap = $urandom_range(0, 5);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    {in_chan3, in_chan2, in_chan1, in_chan0} <= pix;
    in_drain <= drain;
    // in_full only moves at rising edges, so its value at the falling edge
    // is the one the next rising edge sees.
    forever begin
      @(negedge clk);
      if (!in_full) break;
    end
    @(posedge clk);
    predict_word(pix, drain);
    words_sent++;
  endtask

  // One register write, after which the channel is left idle.
  task automatic write_reg(logic [lgcs_pkg::CFG_IDX_W-1:0] idx, int unsigned val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[15:0];
    forever begin
      @(negedge clk);
      if (cfg_ready) break;
    end
    @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      lgcs_pkg::CFG_FRAME_WIDTH:   reg_width = val & 12'hFFF;
      lgcs_pkg::CFG_FRAME_HEIGHT:  reg_height = val & 12'hFFF;
      lgcs_pkg::CFG_CHANNEL_COUNT: reg_chans = val & 3'h7;
      lgcs_pkg::CFG_KAPPA_Q8:      reg_kappa = val & 16'hFFFF;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Registers change only when no score is outstanding and the pipe has settled.
  task automatic wait_idle();
    in_push <= 1'b0;
    while (scores_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_frame(int unsigned w, int unsigned h, int unsigned nch, int unsigned kap);
    wait_idle();
    write_reg(lgcs_pkg::CFG_FRAME_WIDTH, w);
    write_reg(lgcs_pkg::CFG_FRAME_HEIGHT, h);
    write_reg(lgcs_pkg::CFG_CHANNEL_COUNT, nch);
    write_reg(lgcs_pkg::CFG_KAPPA_Q8, kap);
  endtask

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'($urandom_range(0, 40) - 20);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [63:0] rand_pixel();
    return {rand_sample(), rand_sample(), rand_sample(), rand_sample()};
  endfunction

  // One whole frame with random content, then its flush. Some drain words are
  // slipped in while rows arrive; the block must ignore them.
  task automatic send_frame(int unsigned w, int unsigned h);
    int unsigned ew, eh;
    ew = clamp_dim(w, MAXW);
    eh = clamp_dim(h, MAXH);
    for (int i = 0; i < ew * eh; i++) begin
      if ($urandom_range(0, 9) == 0) send_word(rand_pixel(), 1'b1);
      send_word(rand_pixel(), 1'b0);
    end
    for (int i = 0; i < ew; i++) send_word(rand_pixel(), $urandom_range(0, 1));
  endtask

  // Result side: random stalls per word, plus a long hold-off on request.
  initial begin
    int stall;
    score_word_t e;
    out_pop = 1'b0;
    @(posedge rst_n);
    forever begin
      if (pop_hold > 0) begin
        stall = pop_hold;
        pop_hold = 0;
      end else begin
        stall = $urandom_range(0, 5);
      end
      if (stall > 0) begin
        out_pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_pop <= 1'b1;
      forever begin
        @(negedge clk);
        if (!out_empty) break;
      end
      scores_seen++;
      if (scores_due.size() == 0) begin
        $display("%0t: unexpected word, score %0d frame_end %0b",
                 $time, out_score_q8, out_frame_end);
        errors++;
      end else begin
        e = scores_due.pop_front();
        if (out_score_q8 !== e.score) begin
          $display("%0t: score expected %0d actual %0d",
                   $time, $signed(e.score), out_score_q8);
          errors++;
        end
        if (out_frame_end !== e.fend) begin
          $display("%0t: frame_end expected %0b actual %0b",
                   $time, e.fend, out_frame_end);
          errors++;
        end
      end
      @(posedge clk);
    end
  end

  // Hand-picked words: full-scale samples of both signs on all four channels,
  // the largest gradient weight, drain words during input, pixel words
  // during the flush, and a frame that wraps into the next.
  task automatic test_extremes();
    logic [63:0] hi, lo;
    hi = {4{16'h7FFF}};
    lo = {4{16'h8000}};
    set_frame(3, 3, 4, 65535);
    send_word(hi, 1'b0); send_word(lo, 1'b0); send_word(hi, 1'b0);
    send_word(lo, 1'b1);
    send_word(lo, 1'b0); send_word(hi, 1'b0); send_word(lo, 1'b0);
    send_word(hi, 1'b0); send_word(64'h0, 1'b0); send_word(lo, 1'b0);
    send_word(hi, 1'b0); send_word(lo, 1'b1); send_word(64'h0123_4567_89AB_CDEF, 1'b0);
    set_frame(2, 2, 2, 0);
    send_word({16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000}, 1'b0);
    send_word(hi, 1'b0); send_word(lo, 1'b0); send_word(hi, 1'b0);
    send_word(lo, 1'b1); send_word(hi, 1'b0);
  endtask

  // Register values outside their range, and writes to unused indexes.
  task automatic test_clamping();
    set_frame(0, 0, 0, 1);
    write_reg(CFG_SPARE_LO, 16'hFFFF);
    write_reg(CFG_SPARE_HI, 16'h5A5A);
    send_frame(1, 1);
    set_frame(5, 2, 7, 256);
    send_frame(5, 2);
    // Oversized width: part of row 0 goes in, then the width shrinks so the
    // next pixel closes the row and the one-row frame flushes.
    set_frame(4095, 1, 5, 300);
    repeat (3) send_word(rand_pixel(), 1'b0);
    set_frame(4, 1, 5, 300);
    send_word(rand_pixel(), 1'b0);
    repeat (4) send_word(rand_pixel(), $urandom_range(0, 1));
    // Oversized height: three one-pixel rows, then the height shrinks so
    // the fourth row is the last one.
    set_frame(1, 4095, 3, 128);
    repeat (3) send_word(rand_pixel(), 1'b0);
    set_frame(1, 4, 3, 128);
    send_word(rand_pixel(), 1'b0);
    send_word(rand_pixel(), $urandom_range(0, 1));
  endtask

  task automatic test_random_frames();
    int unsigned w, h, goal;
    goal = words_sent + RANDOM_WORDS;
    while (words_sent < goal) begin
      w = $urandom_range(1, 7);
      h = $urandom_range(1, 5);
      case ($urandom_range(0, 3))
        0: set_frame(w, h, $urandom_range(0, 7), 0);
        1: set_frame(w, h, $urandom_range(0, 7), 65535);
        default: set_frame(w, h, $urandom_range(0, 7), $urandom_range(0, 65535));
      endcase
      send_frame(w, h);
    end
  endtask

  // The result side stops for a long stretch while words keep coming, so the
  // internal queue fills and in_full must hold the sender off.
  task automatic test_backpressure();
    set_frame(8, 4, 4, $urandom_range(0, 65535));
    pop_hold = 600;
    send_frame(8, 4);
  endtask

  initial begin
    rst_n = 1'b0;
    in_push = 1'b0;
    in_chan0 = '0; in_chan1 = '0; in_chan2 = '0; in_chan3 = '0;
    in_drain = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    errors = 0; words_sent = 0; scores_seen = 0; frames_done = 0; pop_hold = 0;
    col_in = 0; row_in = 0; col_out = 0; row_out = 0;
    left_pix = '0;
    reg_width = 640; reg_height = 480; reg_chans = 1; reg_kappa = 256;
    for (int i = 0; i < MAXW; i++) begin
      buf_above[i] = '0;
      buf_center[i] = '0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_extremes();
    test_clamping();
    test_backpressure();
    test_random_frames();

    wait_idle();
    $display("tb: %0d words sent, %0d scores checked over %0d frames", words_sent,
             scores_seen, frames_done);
    $display("tb: clamped registers, full-scale samples, drains and a long output stall");
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/lgcs_pkg.sv
rtl/lgcs_front.sv
rtl/lgcs_queue.sv
rtl/lgcs_back.sv
rtl/laplacian_gradient_corner_score_top.sv
bench/tb.sv
